// ===== rtl/cave_automaton_5x5_step_top_assert.svh =====
// Assertion macros for the cave automaton step block.
`ifndef CAVE_AUTOMATON_5X5_STEP_TOP_ASSERT_SVH
`define CAVE_AUTOMATON_5X5_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAVE5_AST_IMPL(LBL, CLK, RSTN, ANT, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CONS)) \
    else $error("cave5 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAVE5_AST_NEXT(LBL, CLK, RSTN, ANT, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CONS)) \
    else $error("cave5 assertion failed");

`endif

// ===== rtl/cave5_pkg.sv =====
// Shared types, constants and helpers of the cave automaton step block.
`default_nettype none

package cave5_pkg;

  localparam int WidthW  = 7;
  localparam int HeightW = 12;
  localparam int NearW   = 4;
  localparam int FarW    = 5;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [WidthW-1:0]  MinWidth  = 7'd3;
  localparam logic [HeightW-1:0] MinHeight = 12'd3;

  localparam logic [WidthW-1:0]  RstWidth  = 7'd44;
  localparam logic [HeightW-1:0] RstHeight = 12'd74;
  localparam logic [NearW-1:0]   RstNear   = 4'd5;
  localparam logic [FarW-1:0]    RstFar    = 5'd2;

  typedef enum logic [1:0] {
    RegMapWidth  = 2'd0,
    RegMapHeight = 2'd1,
    RegNearThr   = 2'd2,
    RegFarLim    = 2'd3
  } reg_idx_t;

  // Which result of the pending line is on its way out.
  typedef enum logic [2:0] {
    PhLower = 3'b001,
    PhUpper = 3'b010,
    PhLast  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [NearW-1:0]   near_thr;
    logic [FarW-1:0]    far_lim;
  } cave5_cfg_t;

  function automatic logic [1:0] cnt3(input logic [2:0] v);
    cnt3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cave5_cfg.sv =====
// Configuration register file with APB-style access and effective-value clamping.
`default_nettype none

module cave5_cfg #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cave5_pkg::AddrW-1:0]   paddr,
  input  wire logic [cave5_pkg::DataW-1:0]   pwdata,
  output logic      [cave5_pkg::DataW-1:0]   prdata,
  output logic                               pready,
  output cave5_pkg::cave5_cfg_t              cfg
);

  logic [cave5_pkg::WidthW-1:0]  width_r;
  logic [cave5_pkg::HeightW-1:0] height_r;
  logic [cave5_pkg::NearW-1:0]   near_r;
  logic [cave5_pkg::FarW-1:0]    far_r;
  cave5_pkg::reg_idx_t           idx;
  logic                          wr_en;

  localparam logic [cave5_pkg::WidthW-1:0] MaxW = cave5_pkg::WidthW'(MAX_WIDTH);

  assign idx    = cave5_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cave5_pkg::RstWidth;
      height_r <= cave5_pkg::RstHeight;
      near_r   <= cave5_pkg::RstNear;
      far_r    <= cave5_pkg::RstFar;
    end else if (wr_en) begin
      case (idx)
        cave5_pkg::RegMapWidth:  width_r  <= pwdata[cave5_pkg::WidthW-1:0];
        cave5_pkg::RegMapHeight: height_r <= pwdata[cave5_pkg::HeightW-1:0];
        cave5_pkg::RegNearThr:   near_r   <= pwdata[cave5_pkg::NearW-1:0];
        cave5_pkg::RegFarLim:    far_r    <= pwdata[cave5_pkg::FarW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cave5_pkg::RegMapWidth:  prdata = cave5_pkg::DataW'(width_r);
      cave5_pkg::RegMapHeight: prdata = cave5_pkg::DataW'(height_r);
      cave5_pkg::RegNearThr:   prdata = cave5_pkg::DataW'(near_r);
      cave5_pkg::RegFarLim:    prdata = cave5_pkg::DataW'(far_r);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r < cave5_pkg::MinWidth) begin
      cfg.width = cave5_pkg::MinWidth;
    end else if (width_r > MaxW) begin
      cfg.width = MaxW;
    end else begin
      cfg.width = width_r;
    end
    cfg.height   = (height_r < cave5_pkg::MinHeight) ? cave5_pkg::MinHeight : height_r;
    cfg.near_thr = near_r;
    cfg.far_lim  = far_r;
  end

endmodule

`default_nettype wire

// ===== rtl/cave5_line.sv =====
// One-line update unit: per-cell 3x3 and 21-cell wall counts and the cave rule.
`default_nettype none

module cave5_line #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic [4:0][MAX_WIDTH-1:0]       rows,
  input  wire logic [MAX_WIDTH-1:0]            wmask,
  input  wire logic [cave5_pkg::WidthW-1:0]    width,
  input  wire logic [cave5_pkg::NearW-1:0]     near_thr,
  input  wire logic [cave5_pkg::FarW-1:0]      far_lim,
  output logic      [MAX_WIDTH-1:0]            res
);

  // Two open cells of padding on each side; cell x sits at pad index x+2.
  logic [4:0][MAX_WIDTH+3:0] pad;

  for (genvar r = 0; r < 5; r++) begin : g_pad
    assign pad[r] = {2'b00, rows[r], 2'b00};
  end

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_cell
    localparam logic [cave5_pkg::WidthW-1:0] XP2 = cave5_pkg::WidthW'(x + 2);
    localparam bit NotFirst = (x != 0);

    logic [3:0] near_cnt;
    logic [3:0] ring_cnt;
    logic [4:0] far_cnt;
    logic       wall;
    logic       interior;

    assign near_cnt = {2'b00, cave5_pkg::cnt3(pad[1][x+3:x+1])}
                    + {2'b00, cave5_pkg::cnt3(pad[2][x+3:x+1])}
                    + {2'b00, cave5_pkg::cnt3(pad[3][x+3:x+1])};
    assign ring_cnt = {2'b00, cave5_pkg::cnt3(pad[0][x+3:x+1])}
                    + {2'b00, cave5_pkg::cnt3(pad[4][x+3:x+1])}
                    + {2'b00, cave5_pkg::cnt3({pad[1][x], pad[2][x], pad[3][x]})}
                    + {2'b00, cave5_pkg::cnt3({pad[1][x+4], pad[2][x+4], pad[3][x+4]})};
    assign far_cnt  = {1'b0, near_cnt} + {1'b0, ring_cnt};

    assign wall     = (near_cnt >= near_thr) || (far_cnt <= far_lim);
    assign interior = NotFirst && (XP2 <= width);
    assign res[x]   = wmask[x] & (interior ? wall : rows[2][x]);
  end

endmodule

`default_nettype wire

// ===== rtl/cave_automaton_5x5_step_top.sv =====
// Top level of the streamed cave automaton step: line store, pending line and result register.
`default_nettype none

// One map line enters and one result line leaves per transfer. Lines 0 and 1 of a map give
// no result; each later line gives the line two above it via the pending-line and result
// registers. The closing line gives three results (the two lines above it, then itself
// marked last), which leave through the single result register while it stalls the input.
// All other lines sustain one transfer per cycle while out_stall is low. The store and line
// counter return to zero after the last line. Configuration must be written over the APB
// port only while no line is in flight; the block itself does not enforce it.
module cave_automaton_5x5_step_top #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [MAX_WIDTH-1:0]          in_source_cells,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [MAX_WIDTH-1:0]          out_result_cells,
  output logic      [cave5_pkg::HeightW-1:0] out_line_index,
  output logic                               out_last_line,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cave5_pkg::AddrW-1:0]   paddr,
  input  wire logic [cave5_pkg::DataW-1:0]   pwdata,
  output logic      [cave5_pkg::DataW-1:0]   prdata,
  output logic                               pready
);

  cave5_pkg::cave5_cfg_t cfg;

  logic [3:0][MAX_WIDTH-1:0]        store_r;
  logic [cave5_pkg::HeightW-1:0]    cnt_r;

  logic                             job_valid_r;
  logic                             job_last_r;
  cave5_pkg::phase_t                job_phase_r;
  logic [cave5_pkg::HeightW-1:0]    job_idx_r;
  logic [4:0][MAX_WIDTH-1:0]        job_win_r;

  logic                             out_valid_r;
  logic [MAX_WIDTH-1:0]             out_cells_r;
  logic [cave5_pkg::HeightW-1:0]    out_idx_r;
  logic                             out_last_r;

  logic [MAX_WIDTH-1:0]             wmask;
  logic [MAX_WIDTH-1:0]             cur;
  logic                             last_in;
  logic                             in_acc;
  logic                             out_load;
  logic                             job_emit;
  logic                             job_final;
  logic                             job_free;
  logic [4:0][MAX_WIDTH-1:0]        line_rows;
  logic [MAX_WIDTH-1:0]             line_res;
  logic [MAX_WIDTH-1:0]             res_cells;
  logic [cave5_pkg::HeightW-1:0]    res_idx;
  logic                             res_last;

  cave5_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_mask
    assign wmask[x] = cave5_pkg::WidthW'(x) < cfg.width;
  end

  assign cur       = in_source_cells & wmask;
  assign last_in   = cnt_r >= (cfg.height - 12'd1);

  assign out_load  = !out_valid_r || !out_stall;
  assign job_emit  = job_valid_r && out_load;
  assign job_final = !job_last_r || (job_phase_r == cave5_pkg::PhLast);
  assign job_free  = !job_valid_r || (out_load && job_final);
  assign in_stall  = !job_free;
  assign in_acc    = in_valid && job_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cnt_r   <= '0;
    end else if (in_acc) begin
      if (last_in) begin
        store_r <= '0;
        cnt_r   <= '0;
      end else begin
        store_r <= {cur, store_r[3], store_r[2], store_r[1]};
        cnt_r   <= cnt_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      job_last_r  <= 1'b0;
      job_phase_r <= cave5_pkg::PhLower;
    end else if (in_acc) begin
      job_valid_r <= cnt_r >= 12'd2;
      job_last_r  <= last_in;
      job_phase_r <= cave5_pkg::PhLower;
    end else if (job_emit) begin
      if (job_final) begin
        job_valid_r <= 1'b0;
      end else if (job_phase_r == cave5_pkg::PhLower) begin
        job_phase_r <= cave5_pkg::PhUpper;
      end else begin
        job_phase_r <= cave5_pkg::PhLast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_idx_r <= cnt_r;
      job_win_r <= {cur, store_r[3], store_r[2], store_r[1], store_r[0]};
    end
  end

  // The upper line of a closing map sees an open line below it.
  always_comb begin
    if (job_phase_r == cave5_pkg::PhUpper) begin
      line_rows = {{MAX_WIDTH{1'b0}}, job_win_r[4], job_win_r[3], job_win_r[2], job_win_r[1]};
    end else begin
      line_rows = job_win_r;
    end
  end

  cave5_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .rows     (line_rows),
    .wmask    (wmask),
    .width    (cfg.width),
    .near_thr (cfg.near_thr),
    .far_lim  (cfg.far_lim),
    .res      (line_res)
  );

  always_comb begin
    case (job_phase_r)
      cave5_pkg::PhLower: begin
        res_cells = (job_idx_r == 12'd2) ? (job_win_r[2] & wmask) : line_res;
        res_idx   = job_idx_r - 12'd2;
        res_last  = 1'b0;
      end
      cave5_pkg::PhUpper: begin
        res_cells = line_res;
        res_idx   = job_idx_r - 12'd1;
        res_last  = 1'b0;
      end
      cave5_pkg::PhLast: begin
        res_cells = job_win_r[4];
        res_idx   = job_idx_r;
        res_last  = 1'b1;
      end
      default: begin
        res_cells = '0;
        res_idx   = '0;
        res_last  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_emit) begin
      out_cells_r <= res_cells;
      out_idx_r   <= res_idx;
      out_last_r  <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_cells = out_cells_r;
  assign out_line_index   = out_idx_r;
  assign out_last_line    = out_last_r;

`include "cave_automaton_5x5_step_top_assert.svh"

  `CAVE5_AST_NEXT(a_map_restart, clk, rst_n, in_acc && last_in, cnt_r == 12'd0)
  `CAVE5_AST_NEXT(a_head_no_job, clk, rst_n, in_acc && (cnt_r < 12'd2), !job_valid_r)
  `CAVE5_AST_IMPL(a_single_phase, clk, rst_n, job_valid_r && !job_last_r, job_phase_r == cave5_pkg::PhLower)
  `CAVE5_AST_NEXT(a_last_marked, clk, rst_n, job_emit && (job_phase_r == cave5_pkg::PhLast), out_valid_r && out_last_r)

endmodule

`default_nettype wire

// ===== tb/sv/cave_automaton_5x5_step_top_test.sv =====
// Self-checking testbench for the streamed cave automaton step block.
`timescale 1ns / 1ps

module cave_automaton_5x5_step_top_test;

  typedef struct {
    logic [63:0] cells;
    logic [11:0] index;
    logic        last;
  } cave_line_t;

  class cave_line_board;
    logic [cave5_pkg::WidthW-1:0]  width;
    logic [cave5_pkg::HeightW-1:0] height;
    logic [cave5_pkg::NearW-1:0]   near_thr;
    logic [cave5_pkg::FarW-1:0]    far_lim;
    logic [63:0]        rows [4];
    int unsigned        line_no;
    cave_line_t         due_lines [$];
    int unsigned        errors;

    function new();
      width    = cave5_pkg::RstWidth;
      height   = cave5_pkg::RstHeight;
      near_thr = cave5_pkg::RstNear;
      far_lim  = cave5_pkg::RstFar;
      foreach (rows[i]) rows[i] = '0;
      line_no = 0;
      errors  = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function int used_width();
      if (width < 3) return 3;
      if (width > 64) return 64;
      return int'(width);
    endfunction

    function logic [63:0] width_mask(input int w);
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    // New value of line win[2], counts taken from the untouched window.
    function logic [63:0] relax_line(input logic [63:0] win [5], input int w);
      logic [63:0] res;
      int near_cnt, far_cnt, x, dx, dy, ax, ay, px;
      res = win[2];
      for (x = 1; x <= w - 2; x++) begin
        near_cnt = 0;
        far_cnt  = 0;
        for (dy = -2; dy <= 2; dy++) begin
          for (dx = -2; dx <= 2; dx++) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            px = x + dx;
            if (!(ax == 2 && ay == 2) && px >= 0 && px <= 63 && win[dy + 2][px]) begin
              far_cnt++;
              if (ax <= 1 && ay <= 1) near_cnt++;
            end
          end
        end
        res[x] = (near_cnt >= int'(near_thr)) || (far_cnt <= int'(far_lim));
      end
      return res & width_mask(w);
    endfunction

    function void queue_line(input logic [63:0] cells, input int unsigned idx,
                             input logic last);
      cave_line_t e;
      e.cells = cells;
      e.index = idx[11:0];
      e.last  = last;
      due_lines.push_back(e);
    endfunction

    function void note_line(input logic [63:0] src);
      int          w;
      int unsigned h, k;
      logic [63:0] wm, cur;
      logic [63:0] win [5];
      w   = used_width();
      h   = (height < 3) ? 3 : int'(height);
      wm  = width_mask(w);
      cur = src & wm;
      k   = line_no;
      if (k >= 2) begin
        for (int i = 0; i < 4; i++) win[i] = rows[i];
        win[4] = cur;
        if (k == 2) queue_line(win[2] & wm, 0, 1'b0);
        else queue_line(relax_line(win, w), k - 2, 1'b0);
      end
      if (k >= h - 1) begin
        for (int i = 0; i < 3; i++) win[i] = rows[i + 1];
        win[3] = cur;
        win[4] = '0;
        queue_line(relax_line(win, w), k - 1, 1'b0);
        queue_line(cur, k, 1'b1);
        foreach (rows[i]) rows[i] = '0;
        line_no = 0;
      end else begin
        for (int i = 0; i < 3; i++) rows[i] = rows[i + 1];
        rows[3] = cur;
        line_no = (k + 1) & 32'hFFF;
      end
    endfunction

    task check_line(input logic [63:0] cells, input logic [11:0] idx, input logic last);
      cave_line_t e;
      if (due_lines.size() == 0) begin
        report($sformatf("result line %0d with no transfer pending", idx));
        return;
      end
      e = due_lines.pop_front();
      if (cells !== e.cells)
        report($sformatf("line %0d cells %h, want %h", e.index, cells, e.cells));
      if (idx !== e.index)
        report($sformatf("line index %0d, want %0d", idx, e.index));
      if (last !== e.last)
        report($sformatf("line %0d last flag %b, want %b", e.index, last, e.last));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [63:0]                   in_source_cells;
  logic                          out_valid;
  logic                          out_stall;
  logic [63:0]                   out_result_cells;
  logic [cave5_pkg::HeightW-1:0] out_line_index;
  logic                          out_last_line;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cave5_pkg::AddrW-1:0]   paddr;
  logic [cave5_pkg::DataW-1:0]   pwdata;
  logic [cave5_pkg::DataW-1:0]   prdata;
  logic                          pready;

  cave_line_board sb = new();
  bit             src_gaps;
  bit             sink_gaps;
  int unsigned    lines_sent;

  cave_automaton_5x5_step_top #(.MAX_WIDTH(64)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_cells  (in_source_cells),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_cells (out_result_cells),
    .out_line_index   (out_line_index),
    .out_last_line    (out_last_line),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall before every transfer while sink_gaps is set.
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = sink_gaps ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_line(out_result_cells, out_line_index, out_last_line);
    end
  end

  task write_reg(input cave5_pkg::reg_idx_t idx, input logic [cave5_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      cave5_pkg::RegMapWidth:  sb.width    = value[cave5_pkg::WidthW-1:0];
      cave5_pkg::RegMapHeight: sb.height   = value[cave5_pkg::HeightW-1:0];
      cave5_pkg::RegNearThr:   sb.near_thr = value[cave5_pkg::NearW-1:0];
      cave5_pkg::RegFarLim:    sb.far_lim  = value[cave5_pkg::FarW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_config(input int w, input int h, input int nt, input int fl);
    drain();
    write_reg(cave5_pkg::RegMapWidth, w);
    write_reg(cave5_pkg::RegMapHeight, h);
    write_reg(cave5_pkg::RegNearThr, nt);
    write_reg(cave5_pkg::RegFarLim, fl);
  endtask

  task send_line(input logic [63:0] cells);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_source_cells <= cells;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_line(cells);
    lines_sent++;
  endtask

  function logic [63:0] rand_line();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return a & b;
      1:       return a | b;
      2:       return a & b & c;
      3:       return a | b | c;
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: return a;
    endcase
  endfunction

  function int rand_width();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(65, 127);
      2:       return 64;
      3:       return 3;
      default: return $urandom_range(4, 63);
    endcase
  endfunction

  function int rand_height();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(13, 40);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  initial begin
    in_valid        <= 1'b0;
    in_source_cells <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_n           <= 1'b0;
    src_gaps   = 1'b0;
    sink_gaps  = 1'b0;
    lines_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // width below minimum, height below minimum, thresholds past the count range
    set_config(0, 0, 15, 31);
    send_line('1);
    send_line('1);
    send_line(64'hA5A5_5A5A_0FF0_F00F);

    // width above maximum, height below minimum, zero thresholds make every interior cell a wall
    set_config(127, 1, 0, 0);
    send_line('0);
    send_line('1);
    send_line(64'h5555_5555_5555_5555);

    // full width, near threshold one past the 3x3 count and far limit at the 21-cell count
    set_config(64, 5, 10, 21);
    repeat (4) send_line('1);
    send_line('0);

    // tallest map, then shrink height mid-map so the next line closes it
    set_config(3, 4095, 5, 2);
    repeat (4) send_line(rand_line());
    drain();
    write_reg(cave5_pkg::RegMapHeight, 3);
    send_line(rand_line());

    set_config(44, 6, 5, 2);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (6) send_line(rand_line());

    while (lines_sent < 480) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      set_config(rand_width(), rand_height(),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) send_line(rand_line());
          if (sb.line_no != 0) begin
            drain();
            write_reg(cave5_pkg::RegMapHeight, $urandom_range(0, 12));
          end
        end
        do begin
          if ($urandom_range(0, 59) == 0) drain();
          send_line(rand_line());
        end while (sb.line_no != 0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cave5_pkg.sv
rtl/cave5_cfg.sv
rtl/cave5_line.sv
rtl/cave_automaton_5x5_step_top.sv
tb/sv/cave_automaton_5x5_step_top_test.sv
